FILE: src/length_prefixed_request_deframer_assert.svh
// Assertion macros used by the request deframer top level.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: src/lprd_pkg.sv
// Types and constants shared by the request deframer modules.
package lprd_pkg;

    localparam int DATA_W      = 8;
    localparam int LEN_W       = 32;
    localparam int OP_W        = 3;
    localparam int ROLE_W      = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int LEN_BYTES   = 4;
    localparam int LEN_CNT_W   = $clog2(LEN_BYTES);

    // Result beat packing.
    localparam int TDATA_W = LEN_W + DATA_W;
    localparam int TUSER_W = OP_W + ROLE_W + 1;

    // Operation kinds.
    localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
    localparam logic [OP_W-1:0] OP_GET     = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL     = 3'd2;
    localparam logic [OP_W-1:0] OP_STATS   = 3'd3;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd4;

    // Byte roles.
    localparam logic [ROLE_W-1:0] ROLE_OPCODE = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_DATA   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PUT_IDX    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GET_IDX    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELETE_IDX = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATS_IDX  = 8'd3;

    // Reset opcode values.
    localparam logic [DATA_W-1:0] PUT_CODE_RST    = 8'd11;
    localparam logic [DATA_W-1:0] GET_CODE_RST    = 8'd13;
    localparam logic [DATA_W-1:0] DELETE_CODE_RST = 8'd12;
    localparam logic [DATA_W-1:0] STATS_CODE_RST  = 8'd21;

    typedef struct packed {
        logic [DATA_W-1:0] put_code;
        logic [DATA_W-1:0] get_code;
        logic [DATA_W-1:0] delete_code;
        logic [DATA_W-1:0] stats_code;
    } codes_t;

    typedef struct packed {
        logic [OP_W-1:0]   op_kind;
        logic [ROLE_W-1:0] byte_role;
        logic              token_index;
        logic [LEN_W-1:0]  token_length;
        logic [DATA_W-1:0] payload_byte;
        logic              frame_end;
    } result_t;

endpackage

FILE: src/lprd_cfg_regs.sv
// Opcode configuration registers of the request deframer.
module lprd_cfg_regs
    import lprd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    output codes_t                 codes
);

    codes_t codes_reg;
    codes_t codes_next;

    always_comb begin
        codes_next = codes_reg;
        if (cfg_valid) begin
            // Indexes past the last register are dropped.
            unique case (cfg_index)
                CFG_PUT_IDX:    codes_next.put_code    = cfg_data;
                CFG_GET_IDX:    codes_next.get_code    = cfg_data;
                CFG_DELETE_IDX: codes_next.delete_code = cfg_data;
                CFG_STATS_IDX:  codes_next.stats_code  = cfg_data;
                default:        codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.put_code    <= PUT_CODE_RST;
            codes_reg.get_code    <= GET_CODE_RST;
            codes_reg.delete_code <= DELETE_CODE_RST;
            codes_reg.stats_code  <= STATS_CODE_RST;
        end else begin
            codes_reg <= codes_next;
        end
    end

    assign codes = codes_reg;

endmodule

FILE: src/lprd_parser.sv
// Input byte register and frame parsing state of the request deframer.
module lprd_parser
    import lprd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  codes_t            codes,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_byte,
    input  logic              res_ready,
    output logic              res_valid,
    output result_t           res
);

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_SPARE  = 2'd3
    } phase_t;

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;

    phase_t            phase_reg,       phase_next;
    logic [OP_W-1:0]   op_reg,          op_next;
    logic [1:0]        tokens_reg,      tokens_next;
    logic              token_num_reg,   token_num_next;
    logic [LEN_CNT_W-1:0] len_cnt_reg,  len_cnt_next;
    logic [LEN_W-1:0]  len_shift_reg,   len_shift_next;
    logic [LEN_W-1:0]  remaining_reg,   remaining_next;

    logic              fire;
    logic              more_tokens;
    logic [LEN_W-1:0]  shifted;
    logic [LEN_W-1:0]  rem_dec;

    assign fire      = in_valid_reg && res_ready;
    assign s_tready  = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;

    assign more_tokens = ({1'b0, token_num_reg} + 2'd1) < tokens_reg;
    assign shifted     = {len_shift_reg[LEN_W-DATA_W-1:0], in_byte_reg};
    assign rem_dec     = remaining_reg - LEN_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        op_next        = op_reg;
        tokens_next    = tokens_reg;
        token_num_next = token_num_reg;
        len_cnt_next   = len_cnt_reg;
        len_shift_next = len_shift_reg;
        remaining_next = remaining_reg;

        res.op_kind      = op_reg;
        res.byte_role    = ROLE_OPCODE;
        res.token_index  = 1'b0;
        res.token_length = '0;
        res.payload_byte = in_byte_reg;
        res.frame_end    = 1'b0;

        unique case (phase_reg)
            PH_LENGTH: begin
                res.byte_role    = ROLE_LENGTH;
                res.token_index  = token_num_reg;
                res.token_length = shifted;
                len_shift_next   = shifted;
                len_cnt_next     = len_cnt_reg + LEN_CNT_W'(1);
                if (len_cnt_reg == LEN_CNT_W'(LEN_BYTES - 1)) begin
                    if (shifted == '0) begin
                        // An empty token closes on its last length byte.
                        remaining_next = '0;
                        len_cnt_next   = '0;
                        if (more_tokens) begin
                            token_num_next = 1'b1;
                            len_shift_next = '0;
                        end else begin
                            phase_next     = PH_OPCODE;
                            token_num_next = 1'b0;
                            res.frame_end  = 1'b1;
                        end
                    end else begin
                        remaining_next = shifted;
                        phase_next     = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res.byte_role    = ROLE_DATA;
                res.token_index  = token_num_reg;
                res.token_length = len_shift_reg;
                remaining_next   = rem_dec;
                if (rem_dec == '0) begin
                    len_cnt_next = '0;
                    if (more_tokens) begin
                        token_num_next = 1'b1;
                        phase_next     = PH_LENGTH;
                        len_shift_next = '0;
                    end else begin
                        phase_next     = PH_OPCODE;
                        token_num_next = 1'b0;
                        res.frame_end  = 1'b1;
                    end
                end
            end
            default: begin
                // The spare phase code behaves as the opcode phase.
                token_num_next = 1'b0;
                len_cnt_next   = '0;
                len_shift_next = '0;
                remaining_next = '0;
                priority if (in_byte_reg == codes.put_code) begin
                    op_next     = OP_PUT;
                    tokens_next = 2'd2;
                end else if (in_byte_reg == codes.get_code) begin
                    op_next     = OP_GET;
                    tokens_next = 2'd1;
                end else if (in_byte_reg == codes.delete_code) begin
                    op_next     = OP_DEL;
                    tokens_next = 2'd1;
                end else if (in_byte_reg == codes.stats_code) begin
                    op_next     = OP_STATS;
                    tokens_next = 2'd0;
                end else begin
                    op_next     = OP_UNKNOWN;
                    tokens_next = 2'd0;
                end
                res.op_kind = op_next;
                if (tokens_next == 2'd0) begin
                    phase_next    = PH_OPCODE;
                    res.frame_end = 1'b1;
                end else begin
                    phase_next = PH_LENGTH;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_OPCODE;
            op_reg        <= OP_PUT;
            tokens_reg    <= '0;
            token_num_reg <= 1'b0;
            len_cnt_reg   <= '0;
            len_shift_reg <= '0;
            remaining_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                phase_reg     <= phase_next;
                op_reg        <= op_next;
                tokens_reg    <= tokens_next;
                token_num_reg <= token_num_next;
                len_cnt_reg   <= len_cnt_next;
                len_shift_reg <= len_shift_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_byte;
        end
    end

endmodule

FILE: src/lprd_out_stage.sv
// Result register that drives the master-side beat of the request deframer.
module lprd_out_stage
    import lprd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

FILE: src/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer.
// Each byte passes through the parser's input register, then the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset: synchronous, active low; opcodes return to 11/13/12/21 and the parser
// waits for an opcode byte. No clearing pass is needed.
module length_prefixed_request_deframer
    import lprd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Slave side; tdata: data_byte[7:0].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,
    // Master side; tdata: token_length[31:0], payload_byte[39:32].
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,
    // tuser: op_kind[2:0], byte_role[4:3], token_index[5].
    output logic [TUSER_W-1:0]     m_tuser,
    output logic                   m_tlast,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

`include "length_prefixed_request_deframer_assert.svh"

    codes_t  codes;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t m_res;

    assign cfg_ready = 1'b1;

    lprd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    lprd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .codes     (codes),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    lprd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {m_res.payload_byte, m_res.token_length};
    assign m_tuser = {m_res.token_index, m_res.byte_role, m_res.op_kind};
    assign m_tlast = m_res.frame_end;

    // An opcode beat carries no token information.
    `LPRD_ASSERT_NOW(a_opcode_clean, aclk, aresetn,
        m_tvalid && m_res.byte_role == ROLE_OPCODE,
        m_res.token_length == '0 && !m_res.token_index)
    // Stats and unknown opcodes end their frame; token-bearing opcodes never do.
    `LPRD_ASSERT_NOW(a_opcode_end, aclk, aresetn,
        m_tvalid && m_res.byte_role == ROLE_OPCODE,
        m_res.frame_end == (m_res.op_kind == OP_STATS || m_res.op_kind == OP_UNKNOWN))
    // Data bytes only follow a nonzero length.
    `LPRD_ASSERT_NOW(a_data_len, aclk, aresetn,
        m_tvalid && m_res.byte_role == ROLE_DATA,
        m_res.token_length != '0)
    // Only put frames reach the second token.
    `LPRD_ASSERT_NOW(a_second_token, aclk, aresetn,
        m_tvalid && m_res.token_index,
        m_res.op_kind == OP_PUT)

endmodule

FILE: test/length_prefixed_request_deframer_test.sv
// Self-checking testbench for the length-prefixed request deframer.
module length_prefixed_request_deframer_test
    import lprd_pkg::*;
();

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 2000;
    localparam int SETTINGS_COUNT = 6;
    localparam int BYTES_PER_SET  = 262;

    // Register indexes past the four opcode registers; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    typedef enum logic [1:0] {
        EXPECT_OPCODE = 2'd0,
        IN_LENGTH     = 2'd1,
        IN_DATA       = 2'd2
    } parse_phase_t;

    class deframe_scoreboard;
        logic [DATA_W-1:0] put_code, get_code, delete_code, stats_code;
        parse_phase_t      phase;
        logic [OP_W-1:0]   cur_op;
        logic [1:0]        tokens_needed;
        logic              token_num;
        logic [1:0]        len_cnt;
        logic [LEN_W-1:0]  len_acc;
        logic [LEN_W-1:0]  remaining;
        result_t           predicted_beats[$];
        int                errors;
        int                beats_checked;
        int                frames_seen;

        function new();
            put_code      = PUT_CODE_RST;
            get_code      = GET_CODE_RST;
            delete_code   = DELETE_CODE_RST;
            stats_code    = STATS_CODE_RST;
            phase         = EXPECT_OPCODE;
            cur_op        = OP_PUT;
            tokens_needed = 2'd0;
            token_num     = 1'b0;
            len_cnt       = 2'd0;
            len_acc       = '0;
            remaining     = '0;
            errors        = 0;
            beats_checked = 0;
            frames_seen   = 0;
        endfunction

        function void set_code(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_PUT_IDX:    put_code    = value;
                CFG_GET_IDX:    get_code    = value;
                CFG_DELETE_IDX: delete_code = value;
                CFG_STATS_IDX:  stats_code  = value;
                default: ;
            endcase
        endfunction

        // Returns 1 when the token just closed was the last one of the frame.
        function bit close_token();
            if (int'(token_num) + 1 < int'(tokens_needed)) begin
                token_num = 1'b1;
                phase     = IN_LENGTH;
                len_cnt   = 2'd0;
                len_acc   = '0;
                remaining = '0;
                return 1'b0;
            end
            phase     = EXPECT_OPCODE;
            token_num = 1'b0;
            len_cnt   = 2'd0;
            remaining = '0;
            return 1'b1;
        endfunction

        function void decode_byte(logic [DATA_W-1:0] b);
            result_t r;
            r = '0;
            r.payload_byte = b;
            case (phase)
                IN_LENGTH: begin
                    r.byte_role    = ROLE_LENGTH;
                    r.token_index  = token_num;
                    len_acc        = {len_acc[LEN_W-DATA_W-1:0], b};
                    len_cnt        = len_cnt + 2'd1;
                    r.token_length = len_acc;
                    if (len_cnt == 2'd0) begin
                        if (len_acc == '0) begin
                            r.frame_end = close_token();
                        end else begin
                            remaining = len_acc;
                            phase     = IN_DATA;
                        end
                    end
                end
                IN_DATA: begin
                    r.byte_role    = ROLE_DATA;
                    r.token_index  = token_num;
                    r.token_length = len_acc;
                    remaining      = remaining - 1;
                    if (remaining == '0)
                        r.frame_end = close_token();
                end
                default: begin
                    r.byte_role = ROLE_OPCODE;
                    token_num   = 1'b0;
                    len_cnt     = 2'd0;
                    len_acc     = '0;
                    remaining   = '0;
                    // Matching order decides between codes that coincide.
                    if (b == put_code) begin
                        cur_op = OP_PUT;
                        tokens_needed = 2'd2;
                    end else if (b == get_code) begin
                        cur_op = OP_GET;
                        tokens_needed = 2'd1;
                    end else if (b == delete_code) begin
                        cur_op = OP_DEL;
                        tokens_needed = 2'd1;
                    end else if (b == stats_code) begin
                        cur_op = OP_STATS;
                        tokens_needed = 2'd0;
                    end else begin
                        cur_op = OP_UNKNOWN;
                        tokens_needed = 2'd0;
                    end
                    if (tokens_needed == 2'd0) begin
                        phase       = EXPECT_OPCODE;
                        r.frame_end = 1'b1;
                    end else begin
                        phase = IN_LENGTH;
                    end
                end
            endcase
            r.op_kind = cur_op;
            predicted_beats.push_back(r);
        endfunction

        function int pending();
            return predicted_beats.size();
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser, logic tlast);
            result_t want;
            if (predicted_beats.size() == 0) begin
                report($sformatf("result beat with no byte outstanding, tdata=%h", tdata));
                return;
            end
            want = predicted_beats.pop_front();
            beats_checked++;
            if (want.frame_end)
                frames_seen++;
            if (tuser[OP_W-1:0] !== want.op_kind)
                report($sformatf("beat %0d op_kind %0d, expected %0d",
                                 beats_checked, tuser[OP_W-1:0], want.op_kind));
            if (tuser[OP_W+ROLE_W-1:OP_W] !== want.byte_role)
                report($sformatf("beat %0d byte_role %0d, expected %0d",
                                 beats_checked, tuser[OP_W+ROLE_W-1:OP_W], want.byte_role));
            if (tuser[OP_W+ROLE_W] !== want.token_index)
                report($sformatf("beat %0d token_index %0d, expected %0d",
                                 beats_checked, tuser[OP_W+ROLE_W], want.token_index));
            if (tdata[LEN_W-1:0] !== want.token_length)
                report($sformatf("beat %0d token_length %h, expected %h",
                                 beats_checked, tdata[LEN_W-1:0], want.token_length));
            if (tdata[LEN_W+DATA_W-1:LEN_W] !== want.payload_byte)
                report($sformatf("beat %0d payload_byte %h, expected %h",
                                 beats_checked, tdata[LEN_W+DATA_W-1:LEN_W],
                                 want.payload_byte));
            if (tlast !== want.frame_end)
                report($sformatf("beat %0d frame_end %0b, expected %0b",
                                 beats_checked, tlast, want.frame_end));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic [TUSER_W-1:0]     m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    deframe_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;

    length_prefixed_request_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Result side: check the beat taken at this edge, then choose the next stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.decode_byte(value);
        bytes_sent++;
    endtask

    // Length bytes keep tokens short (mostly under ten bytes, rarely up to 511).
    function automatic logic [DATA_W-1:0] next_fill_byte();
        if (sb.phase != IN_LENGTH)
            return DATA_W'($urandom_range(255));
        case (sb.len_cnt)
            2'd2:    return ($urandom_range(99) < 4) ? 8'd1 : 8'd0;
            2'd3:    return ($urandom_range(99) < 10) ? DATA_W'($urandom_range(255))
                                                     : DATA_W'($urandom_range(8));
            default: return 8'd0;
        endcase
    endfunction

    task automatic finish_frame();
        while (sb.phase != EXPECT_OPCODE)
            send_byte(next_fill_byte());
    endtask

    function automatic logic [DATA_W-1:0] unknown_opcode();
        logic [DATA_W-1:0] b;
        do b = DATA_W'($urandom_range(255));
        while (b == sb.put_code || b == sb.get_code || b == sb.delete_code ||
               b == sb.stats_code);
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] token_opcode();
        case ($urandom_range(2))
            0:       return sb.put_code;
            1:       return sb.get_code;
            default: return sb.delete_code;
        endcase
    endfunction

    // A frame cut short where the following bytes still form a short token:
    // after three length bytes or somewhere inside the data.
    task automatic send_broken_frame();
        send_byte(token_opcode());
        while (sb.phase == IN_LENGTH && sb.len_cnt != 2'd3)
            send_byte(next_fill_byte());
        if (sb.phase == IN_LENGTH && $urandom_range(1) == 0)
            return;
        if (sb.phase == IN_LENGTH)
            send_byte(next_fill_byte());
        if (sb.phase == IN_DATA)
            repeat ($urandom_range(0, int'(sb.remaining) - 1))
                send_byte(DATA_W'($urandom_range(255)));
    endtask

    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_byte(sb.put_code);
        else if (pick < 50)
            send_byte(sb.get_code);
        else if (pick < 65)
            send_byte(sb.delete_code);
        else if (pick < 75)
            send_byte(sb.stats_code);
        else if (pick < 85)
            send_byte(unknown_opcode());
        else if (pick < 92)
            send_byte(DATA_W'($urandom_range(255)));
        else begin
            send_broken_frame();
            return;
        end
        finish_frame();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_code(idx, value);
    endtask

    task automatic apply_codes(input logic [DATA_W-1:0] put_v, input logic [DATA_W-1:0] get_v,
                               input logic [DATA_W-1:0] del_v, input logic [DATA_W-1:0] stats_v);
        finish_frame();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(CFG_PUT_IDX, put_v);
        write_reg(CFG_GET_IDX, get_v);
        write_reg(CFG_DELETE_IDX, del_v);
        write_reg(CFG_STATS_IDX, stats_v);
        write_reg(CFG_UNUSED_LO, DATA_W'($urandom_range(255)));
        write_reg(CFG_UNUSED_HI, DATA_W'($urandom_range(255)));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL length_prefixed_request_deframer");
        $finish;
    end

    initial begin
        int set_bytes;
        sb            = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 27;
        recv_idle_pct = 53;
        bytes_sent    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset opcodes: stats, unknown at both byte extremes, get with an empty
        // token, delete with a one-byte token, put with an empty and a two-byte token.
        send_byte(STATS_CODE_RST);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(GET_CODE_RST);
        repeat (4) send_byte(8'h00);
        send_byte(DELETE_CODE_RST);
        repeat (3) send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h5A);
        send_byte(PUT_CODE_RST);
        repeat (7) send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);

        for (int s = 0; s < SETTINGS_COUNT; s++) begin
            case (s / 2)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (s)
                1: apply_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
                2: apply_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3: apply_codes(8'h01, 8'h40, 8'h40, 8'h40);
                4: apply_codes(8'hC4, 8'hC5, 8'h33, 8'h33);
                default: apply_codes(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
                                     DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)));
            endcase
            set_bytes = bytes_sent;
            while (bytes_sent - set_bytes < BYTES_PER_SET)
                send_random_frame();
        end

        // A put whose first token has every length bit set never completes; it
        // goes last so the top bits of the length show up in the results.
        finish_frame();
        send_byte(sb.put_code);
        repeat (4) send_byte(8'hFF);
        repeat (12) send_byte(DATA_W'($urandom_range(255)));
        s_tvalid <= 1'b0;

        for (int i = 0; i < DRAIN_CYCLES && sb.pending() != 0; i++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected result beats never arrived", sb.pending()));

        $display("Sent %0d request bytes; %0d result beats checked, %0d frames completed,",
                 bytes_sent, sb.beats_checked, sb.frames_seen);
        $display("across %0d opcode settings and three flow-control patterns.",
                 SETTINGS_COUNT + 1);
        if (sb.errors == 0)
            $display("PASS length_prefixed_request_deframer");
        else
            $display("FAIL length_prefixed_request_deframer");
        $finish;
    end
endmodule
